[rtl/bmas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmas_pkg
// Shared constants and types of the battery moving-average scaler.
// ----------------------------------------------------------------------------
package bmas_pkg;

  localparam int unsigned WINDOW_LEN = 150;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SCALE_W    = 14;
  localparam int unsigned MV_W       = 14;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned POS_W      = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int unsigned DCNT_W     = $clog2(SUM_W);
  localparam int unsigned PROD_W     = SAMPLE_W + SCALE_W;
  localparam int unsigned FRAC_W     = 12;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(11550);

  // Register index within the configuration space (byte address / 4).
  localparam logic [0:0] REG_SCALE_NUM = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MUL,
    ST_LOAD
  } bmas_state_e;

endpackage
`default_nettype wire

[rtl/bmas_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmas_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmas_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 150
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/battery_moving_average_scaler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_moving_average_scaler
// Boxcar moving average of battery ADC samples with a millivolt scale.
// ----------------------------------------------------------------------------
// Each sample accepted on the slave stream is written into a 150-entry ring
// window held in a synchronous RAM, and a running sum of the filled entries is
// kept alongside. Until the window has filled, the mean covers only the
// samples received so far. Every sample yields exactly one result transaction
// carrying the truncated mean and floor(mean * scale_num / 4096), which is the
// cell voltage in millivolts at the reset scale. From acceptance to a
// loaded result, a sample passes through the RAM read of the outgoing
// entry, the read-modify-write of the sum, the bit-serial restoring
// divider (one quotient bit per cycle over the 20-bit sum), the scale
// multiply and the output load. The
// next sample is accepted as soon as the sequencer is back in idle, even
// while the previous result still sits in the output register; if that
// register has not been emptied by then, the sequencer waits before loading.
// The scale register sits at byte address 0 of the APB-style port and should
// only be written while no sample is in flight.
// ----------------------------------------------------------------------------
module battery_moving_average_scaler (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Slave stream. tdata: sample [11:0], zero padding [15:12].
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  input  wire logic [bmas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Master stream. tdata: cell_millivolts [13:0], mean_raw [25:14],
  // zero padding [31:26].
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output      logic [bmas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bmas_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bmas_pkg::APB_DATA_W-1:0]    pwdata,
  output      logic [bmas_pkg::APB_DATA_W-1:0]    prdata,
  output      logic                               pready
);

  import bmas_pkg::*;

  // Sequencer state.
  bmas_state_e state_q, state_d;

  // Configuration.
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_wr;

  // Window bookkeeping.
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic                full;

  // RAM port signals.
  logic                ram_re;
  logic                ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Divider.
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [DCNT_W-1:0] dcnt_q;
  logic              div_last;

  // Multiplier and output register.
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] mean;
  logic                out_valid_q;
  logic [MV_W-1:0]     out_mv_q;
  logic [SAMPLE_W-1:0] out_mean_q;
  logic                out_free;
  logic                out_load;

  logic in_accept;

  // --------------------------------------------------------------------------
  // Configuration port. The register index is the byte address divided by 4.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1:2] == REG_SCALE_NUM);

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_SCALE_NUM) begin
      prdata = APB_DATA_W'(scale_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_wr) begin
      scale_q <= pwdata[SCALE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Window RAM. The outgoing entry is read in the accept cycle and the new
  // sample written back in the next cycle; as only one sample is in flight
  // at a time, a read never overlaps a pending write to the same entry.
  // --------------------------------------------------------------------------
  bmas_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign div_last  = (dcnt_q == DCNT_W'(SUM_W - 1));
  assign out_free  = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid;
      end
      ST_READ: ram_we   = 1'b1;
      ST_DIV:  ;
      ST_MUL:  ;
      ST_LOAD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Running sum, write pointer and fill count. Once the window is full the
  // entry being overwritten leaves the sum before the new sample joins it.
  // --------------------------------------------------------------------------
  assign full = (fill_q == CNT_W'(WINDOW_LEN));

  always_comb begin
    sum_d = sum_q + SUM_W'(sample_q);
    if (full) begin
      sum_d = sum_q - SUM_W'(ram_rdata) + SUM_W'(sample_q);
    end
    pos_d = pos_q + POS_W'(1);
    if (pos_q == POS_W'(WINDOW_LEN - 1)) begin
      pos_d = '0;
    end
    fill_d = full ? fill_q : fill_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (state_q == ST_READ) begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: sum / fill_count, one quotient bit per cycle. The
  // remainder always stays below the divisor, so it fits the count width.
  // --------------------------------------------------------------------------
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, fill_q});

  always_comb begin
    rem_d = rem_ge ? CNT_W'(rem_sh - {1'b0, fill_q}) : rem_sh[CNT_W-1:0];
    quo_d = {quo_q[SUM_W-2:0], rem_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (state_q == ST_READ) begin
      dcnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // The sum never exceeds fill_count times the largest sample, so the
  // quotient fits the sample width.
  assign mean = quo_q[SAMPLE_W-1:0];

  // --------------------------------------------------------------------------
  // Scale multiply and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(mean) * PROD_W'(scale_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mv_q   <= prod_q[FRAC_W +: MV_W];
      out_mean_q <= mean;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_mean_q, out_mv_q});

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(WINDOW_LEN))
    else $error("write pointer beyond window");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (fill_q != '0))
    else $error("division by a zero fill count");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(sum_q) <= 32'(fill_q) * 32'(4095)))
    else $error("running sum exceeds filled entries");

  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_READ) && $past(ram_re))
    else $error("accepted sample did not start a window read");

endmodule
`default_nettype wire

[tb/sv/battery_average_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_average_checker
// Passive checker for the battery moving-average scaler.
// ----------------------------------------------------------------------------
// Follows the sample stream, the reading stream and the configuration port.
// Each accepted sample moves a private copy of the averaging window forward,
// and the expected reading is queued. Each accepted reading is checked
// against the oldest queued one. Reads of the scale register are checked too.
// ----------------------------------------------------------------------------
module battery_average_checker
  import bmas_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  input  wire logic                    s_axis_tready,
  // tdata: sample [11:0], zero padding [15:12].
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // tdata: cell_millivolts [13:0], mean_raw [25:14], zero padding [31:26].
  input  wire logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  input  wire logic [APB_DATA_W-1:0]   prdata,
  input  wire logic                    pready,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           samples_o,
  output int                           readings_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [MV_W-1:0]     cell_mv;
  } reading_t;

  reading_t            expected_readings [$];
  reading_t            want;
  logic [MV_W-1:0]     got_mv;
  logic [SAMPLE_W-1:0] got_mean;

  // Private copy of the block's state.
  logic [SAMPLE_W-1:0] window_mem [WINDOW_LEN];
  logic [POS_W-1:0]    wr_pos;
  logic [CNT_W-1:0]    fill_cnt;
  logic [SUM_W-1:0]    sum_acc;
  logic [SCALE_W-1:0]  scale_reg;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count_o++;
  endtask

  // Moves the window on by one sample and works out the reading it gives.
  task automatic predict_reading(input logic [SAMPLE_W-1:0] smp, output reading_t r);
    logic [PROD_W-1:0] prod;
    if (fill_cnt >= CNT_W'(WINDOW_LEN)) begin
      sum_acc = sum_acc - SUM_W'(window_mem[wr_pos]);
    end
    window_mem[wr_pos] = smp;
    sum_acc = sum_acc + SUM_W'(smp);
    wr_pos = (wr_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : wr_pos + 1'b1;
    if (fill_cnt < CNT_W'(WINDOW_LEN)) begin
      fill_cnt = fill_cnt + 1'b1;
    end
    r.mean = SAMPLE_W'(sum_acc / SUM_W'(fill_cnt));
    prod = PROD_W'(r.mean) * PROD_W'(scale_reg);
    r.cell_mv = MV_W'(prod >> FRAC_W);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_LEN; k++) window_mem[k] = '0;
      wr_pos = '0;
      fill_cnt = '0;
      sum_acc = '0;
      scale_reg = SCALE_RESET;
      expected_readings.delete();
      fail_count_o = 0;
      pending_o = 0;
      samples_o = 0;
      readings_o = 0;
    end else begin
      if (psel && penable && pready && (paddr[APB_ADDR_W-1:2] == REG_SCALE_NUM)) begin
        if (pwrite) begin
          scale_reg = pwdata[SCALE_W-1:0];
        end else if (prdata !== APB_DATA_W'(scale_reg)) begin
          report_mismatch($sformatf("scale_num read back as %0d, expected %0d",
                                    prdata, scale_reg));
        end
      end
      // Readings are taken before samples, so a reading can never be matched
      // against a sample accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got_mv   = m_axis_tdata[MV_W-1:0];
        got_mean = m_axis_tdata[MV_W+SAMPLE_W-1:MV_W];
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("reading %0d arrived with none outstanding",
                                    readings_o));
        end else begin
          want = expected_readings.pop_front();
          if (got_mean !== want.mean) begin
            report_mismatch($sformatf("reading %0d mean_raw %0d, expected %0d",
                                      readings_o, got_mean, want.mean));
          end
          if (got_mv !== want.cell_mv) begin
            report_mismatch($sformatf("reading %0d cell_millivolts %0d, expected %0d",
                                      readings_o, got_mv, want.cell_mv));
          end
        end
        readings_o++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_reading(s_axis_tdata[SAMPLE_W-1:0], want);
        expected_readings.push_back(want);
        samples_o++;
      end
      pending_o = expected_readings.size();
    end
  end

endmodule

[tb/sv/tb_battery_moving_average_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_moving_average_scaler
// Stimulus and verdict for the battery moving-average scaler.
// ----------------------------------------------------------------------------
// Sends a short directed set of samples at the reset scale, then several
// random phases under a range of scale settings and mixes of sender and
// receiver idling. Scale writes happen only once every outstanding
// reading has come back. A separate checker predicts and compares every
// reading; this module only drives the block and reports the outcome.
// ----------------------------------------------------------------------------
module tb_battery_moving_average_scaler;
  import bmas_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int CYCLE_LIMIT  = 200000;
  // Long enough to cover any stray reading that might follow the last
  // expected one.
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 20;

  localparam logic [APB_ADDR_W-1:0] ADDR_SCALE_NUM = {REG_SCALE_NUM, 2'b00};
  // Lies outside the register map; writes there must change nothing.
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;
  localparam logic [SCALE_W-1:0]    SCALE_MAX      = '1;
  localparam logic [SCALE_W-1:0]    SCALE_MIN      = '0;
  localparam logic [SAMPLE_W-1:0]   FULL_SCALE     = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int fail_count;
  int pending_readings;
  int samples_sent;
  int readings_checked;
  int cycle_count = 0;

  // Idling rates in percent; changed only between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Slowly wandering battery level around which most random samples sit.
  int battery_level = 3000;

  // Extremes, every bit at both values, and the warm-up of the window: the
  // first samples after reset are averaged over only what has arrived.
  logic [SAMPLE_W-1:0] directed_samples [N_DIRECTED] = '{
    12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h001, 12'hFFE, 12'hAAA, 12'h555,
    12'h800, 12'h7FF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h4D2,
    12'hBB8, 12'h001, 12'hFFF, 12'h000
  };

  battery_moving_average_scaler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  battery_average_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending_readings),
    .samples_o     (samples_sent),
    .readings_o    (readings_checked)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The receiver decides afresh at every falling edge whether it will take a
  // reading at the next rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding",
               cycle_count, pending_readings);
      $display("status: fail");
      $finish;
    end
  end

  // Most samples hover near a battery level with a little noise; some are
  // rail values or fully random, and now and then the level jumps as a load
  // step would make it.
  function automatic logic [SAMPLE_W-1:0] battery_like_sample();
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 2) begin
      battery_level = $urandom_range(4095);
    end
    if (pick < 6) begin
      value = 0;
    end else if (pick < 10) begin
      value = 4095;
    end else if (pick < 25) begin
      value = $urandom_range(4095);
    end else begin
      value = battery_level + $urandom_range(64) - 32;
      if (value < 0) value = 0;
      if (value > 4095) value = 4095;
    end
    return value[SAMPLE_W-1:0];
  endfunction

  // Presents one sample, after a random number of idle cycles, and holds it
  // until the transaction completes.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_TDATA_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops the sample stream and waits until every reading has come back, so
  // that the block is idle again.
  task automatic wait_for_readings();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_readings != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Writes the scale with random bits above its width, which the block must
  // drop, and reads it back for the checker.
  task automatic set_scale(input logic [SCALE_W-1:0] scale);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[SCALE_W-1:0] = scale;
    apb_access(1'b1, ADDR_SCALE_NUM, word);
    apb_access(1'b0, ADDR_SCALE_NUM, '0);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset scale, which is read back first.
    set_idling(18, 86);
    apb_access(1'b0, ADDR_SCALE_NUM, '0);
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    wait_for_readings();

    // Largest scale; a write outside the map must leave it alone.
    set_scale(SCALE_MAX);
    apb_access(1'b1, ADDR_UNMAPPED, $urandom);
    apb_access(1'b0, ADDR_SCALE_NUM, '0);
    repeat (160) send_sample(battery_like_sample());
    wait_for_readings();

    // Idling the other way round, first at zero scale, then a random one.
    set_idling(86, 18);
    set_scale(SCALE_MIN);
    repeat (50) send_sample(battery_like_sample());
    wait_for_readings();
    set_scale(SCALE_W'($urandom_range(16383)));
    repeat (110) send_sample(battery_like_sample());
    wait_for_readings();

    // No idling. A full window of full-scale samples drives the running sum
    // and the product to their highest values.
    set_idling(0, 0);
    set_scale(SCALE_MAX);
    repeat (WINDOW_LEN) send_sample(FULL_SCALE);
    repeat (40) send_sample(battery_like_sample());
    wait_for_readings();

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("summary: %0d samples sent, %0d readings checked, window turned over %0d times",
             samples_sent, readings_checked, samples_sent / WINDOW_LEN);
    $display("summary: scales reset, maximum, zero and random; three idling mixes");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
